/* design/humidity_temp_readout_decoder_assert.svh */
// ---------------------------------------------------------------------------
// humidity_temp_readout_decoder assertion macros
// concurrent checks on the rising clock edge, masked during reset
// ---------------------------------------------------------------------------
`ifndef HUMIDITY_TEMP_READOUT_DECODER_ASSERT_SVH
`define HUMIDITY_TEMP_READOUT_DECODER_ASSERT_SVH

`ifndef ASSERT_OFF
`define HTRD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define HTRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HTRD_ASSERT_SAME(label, ante, cons, msg)
`define HTRD_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* design/htrd_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// htrd_pkg
// shared types, constants and crc helper of the readout frame decoder
// ---------------------------------------------------------------------------
package htrd_pkg;

  localparam int WORD_W   = 16;
  localparam int CHECK_W  = 8;
  localparam int SCALE_W  = 15;
  localparam int PROD_W   = WORD_W + SCALE_W;
  localparam int TEMP_W   = 15;
  localparam int HUM_W    = 16;
  localparam int SERIAL_W = 32;
  localparam int HPROD_W  = 26;
  localparam int MAG_W    = 30;

  localparam logic [CHECK_W-1:0] CRC_POLY = 8'h31;
  localparam logic [CHECK_W-1:0] CRC_INIT = 8'hff;

  localparam logic [SCALE_W-1:0] TEMP_SCALE = 15'd17500;
  localparam logic [SCALE_W-1:0] HUM_SCALE  = 15'd1000;
  localparam logic [31:0]        TEMP_OFFSET = 32'd294907500;

  localparam logic [TEMP_W-1:0]   TEMP_FAIL   = '1;
  localparam logic [HUM_W-1:0]    HUM_FAIL    = '1;
  localparam logic [SERIAL_W-1:0] SERIAL_FAIL = '1;

  typedef enum logic [1:0] {
    CMD_MEASURE    = 2'd0,
    CMD_SERIAL     = 2'd1,
    CMD_SOFT_RESET = 2'd2
  } cmd_t;

  typedef struct packed {
    logic              ok;
    logic [WORD_W-1:0] word;
    logic [PROD_W-1:0] prod;
  } lane_res_t;

  typedef struct packed {
    logic                hum_ok;
    logic                temp_ok;
    logic                frame_status;
  } out_flags_t;

  typedef struct packed {
    logic [SERIAL_W-1:0] serial_word;
    logic [HUM_W-1:0]    humidity;
    logic [TEMP_W-1:0]   temperature;
  } out_data_t;

  function automatic logic [CHECK_W-1:0] crc8_byte(
    input logic [CHECK_W-1:0] crc,
    input logic [CHECK_W-1:0] data
  );
    logic [CHECK_W-1:0] c;
    c = crc ^ data;
    for (int b = 0; b < CHECK_W; b++) begin
      c = c[CHECK_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

/* design/htrd_lane.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// htrd_lane
// one word lane: crc check against the received byte and scaling multiply
// ---------------------------------------------------------------------------
module htrd_lane (
  input  logic                                clk,
  input  logic                                en,
  input  logic [htrd_pkg::WORD_W-1:0]         word,
  input  logic [htrd_pkg::CHECK_W-1:0]        check,
  input  logic [htrd_pkg::SCALE_W-1:0]        scale,
  output htrd_pkg::lane_res_t                 res
);

  logic [htrd_pkg::CHECK_W-1:0] crc_hi;
  logic [htrd_pkg::CHECK_W-1:0] crc_lo;
  htrd_pkg::lane_res_t          res_r;
  htrd_pkg::lane_res_t          res_nxt;

  always_comb begin
    crc_hi = htrd_pkg::crc8_byte(htrd_pkg::CRC_INIT, word[15:8]);
    crc_lo = htrd_pkg::crc8_byte(crc_hi, word[7:0]);
    res_nxt.ok   = (crc_lo == check);
    res_nxt.word = word;
    res_nxt.prod = htrd_pkg::PROD_W'(word) * htrd_pkg::PROD_W'(scale);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

/* design/htrd_merge.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// htrd_merge
// combines both lanes: offset and sign, divide by 65535, field selection
// ---------------------------------------------------------------------------
module htrd_merge (
  input  logic                 clk,
  input  logic                 en1,
  input  logic                 en2,
  input  logic                 en3,
  input  htrd_pkg::cmd_t       cmd,
  input  htrd_pkg::lane_res_t  lane_a,
  input  htrd_pkg::lane_res_t  lane_b,
  output htrd_pkg::out_flags_t flags,
  output htrd_pkg::out_data_t  data
);

  htrd_pkg::cmd_t                cmd1_r;
  htrd_pkg::cmd_t                cmd2_r;
  logic                          a_ok2_r;
  logic                          b_ok2_r;
  logic [htrd_pkg::WORD_W-1:0]   wa2_r;
  logic [htrd_pkg::WORD_W-1:0]   wb2_r;
  logic                          neg2_r;
  logic [htrd_pkg::MAG_W-1:0]    mag2_r;
  logic [htrd_pkg::HPROD_W-1:0]  hprod2_r;
  logic [31:0]                   diff;
  logic [31:0]                   diff_abs;
  logic [31:0]                   tsum;
  logic [31:0]                   hsum;
  logic [htrd_pkg::TEMP_W-1:0]   tq;
  logic [htrd_pkg::TEMP_W-1:0]   tval;
  logic [htrd_pkg::HUM_W-1:0]    hq;
  htrd_pkg::out_flags_t          flags_r;
  htrd_pkg::out_flags_t          flags_nxt;
  htrd_pkg::out_data_t           data_r;
  htrd_pkg::out_data_t           data_nxt;

  // signed offset removal, kept as sign and magnitude
  always_comb begin
    diff     = 32'(lane_a.prod) - htrd_pkg::TEMP_OFFSET;
    diff_abs = diff[31] ? (32'd0 - diff) : diff;
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      cmd1_r <= cmd;
    end
    if (en2) begin
      cmd2_r   <= cmd1_r;
      a_ok2_r  <= lane_a.ok;
      b_ok2_r  <= lane_b.ok;
      wa2_r    <= lane_a.word;
      wb2_r    <= lane_b.word;
      neg2_r   <= diff[31];
      mag2_r   <= diff_abs[htrd_pkg::MAG_W-1:0];
      hprod2_r <= lane_b.prod[htrd_pkg::HPROD_W-1:0];
    end
  end

  // floor(x / 65535) = (x + (x >> 16) + 1) >> 16 for x below 2^30
  always_comb begin
    tsum = 32'(mag2_r) + 32'(mag2_r >> 16) + 32'd1;
    hsum = 32'(hprod2_r) + 32'(hprod2_r >> 16) + 32'd1;
    tq   = tsum[30:16];
    hq   = hsum[31:16];
    tval = neg2_r ? (htrd_pkg::TEMP_W'(0) - tq) : tq;

    flags_nxt.frame_status = !(a_ok2_r && b_ok2_r);
    flags_nxt.temp_ok      = a_ok2_r;
    flags_nxt.hum_ok       = b_ok2_r;
    data_nxt               = '0;

    unique case (cmd2_r)
      htrd_pkg::CMD_SERIAL: begin
        data_nxt.serial_word = (a_ok2_r && b_ok2_r) ? {wa2_r, wb2_r}
                                                    : htrd_pkg::SERIAL_FAIL;
      end
      htrd_pkg::CMD_SOFT_RESET: begin
        data_nxt = '0;
      end
      default: begin
        data_nxt.temperature = a_ok2_r ? tval : htrd_pkg::TEMP_FAIL;
        data_nxt.humidity    = b_ok2_r ? hq : htrd_pkg::HUM_FAIL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      flags_r <= flags_nxt;
      data_r  <= data_nxt;
    end
  end

  assign flags = flags_r;
  assign data  = data_r;

endmodule

/* design/humidity_temp_readout_decoder.sv */
`timescale 1ns / 1ps
// pipeline: an accepted frame passes the lane registers, then the offset registers, then the output register
// throughput: one frame per cycle while the output is not stalled; two crc/multiply lanes, then offset, then divide
// a stalled output holds its result while the two inner stages keep filling
// reset: rst_n synchronous active low clears all stage valid flags
// ---------------------------------------------------------------------------
// humidity_temp_readout_decoder
// decodes a six-byte sensor readout frame into temperature, humidity, serial
// ---------------------------------------------------------------------------
module humidity_temp_readout_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,  // word_a, check_a, word_b, check_b
  input  logic [1:0]  in_tuser,  // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata, // temperature, humidity, serial_word, pad
  output logic [2:0]  out_tuser  // frame_status, temp_ok, hum_ok
);

`include "humidity_temp_readout_decoder_assert.svh"

  logic                 v1_r;
  logic                 v1_nxt;
  logic                 v2_r;
  logic                 v2_nxt;
  logic                 vo_r;
  logic                 vo_nxt;
  logic                 rdy1;
  logic                 rdy2;
  logic                 rdyo;
  htrd_pkg::lane_res_t  lane_a;
  htrd_pkg::lane_res_t  lane_b;
  htrd_pkg::out_flags_t flags;
  htrd_pkg::out_data_t  data;

  always_comb begin
    rdyo   = !vo_r || out_tready;
    rdy2   = !v2_r || rdyo;
    rdy1   = !v1_r || rdy2;
    v1_nxt = rdy1 ? in_tvalid : v1_r;
    v2_nxt = rdy2 ? v1_r : v2_r;
    vo_nxt = rdyo ? v2_r : vo_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      vo_r <= vo_nxt;
    end
  end

  htrd_lane u_lane_a (
    .clk   (clk),
    .en    (rdy1),
    .word  (in_tdata[15:0]),
    .check (in_tdata[23:16]),
    .scale (htrd_pkg::TEMP_SCALE),
    .res   (lane_a)
  );

  htrd_lane u_lane_b (
    .clk   (clk),
    .en    (rdy1),
    .word  (in_tdata[39:24]),
    .check (in_tdata[47:40]),
    .scale (htrd_pkg::HUM_SCALE),
    .res   (lane_b)
  );

  htrd_merge u_merge (
    .clk    (clk),
    .en1    (rdy1),
    .en2    (rdy2),
    .en3    (rdyo),
    .cmd    (htrd_pkg::cmd_t'(in_tuser)),
    .lane_a (lane_a),
    .lane_b (lane_b),
    .flags  (flags),
    .data   (data)
  );

  assign in_tready  = rdy1;
  assign out_tvalid = vo_r;
  assign out_tdata  = {1'b0, data};
  assign out_tuser  = flags;

  `HTRD_ASSERT_SAME(a_status_match, out_tvalid,
    out_tuser[0] != (out_tuser[1] && out_tuser[2]), "frame status disagrees with crc flags")
  `HTRD_ASSERT_SAME(a_temp_fail, out_tvalid && !out_tuser[1],
    out_tdata[14:0] == 15'h7fff || out_tdata[14:0] == 15'h0000, "bad temperature on crc fail")
  `HTRD_ASSERT_SAME(a_hum_range, out_tvalid && out_tuser[2],
    out_tdata[30:15] <= 16'd1000, "humidity above full scale")
  `HTRD_ASSERT_NEXT(a_take_fill, in_tvalid && in_tready,
    v1_r, "accepted frame not held in lane stage")

endmodule

/* sim/tb_humidity_temp_readout_decoder.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_humidity_temp_readout_decoder
// self-checking bench: frames from a queue go through a bursty driver, a
// local decoder predicts each result and a monitor compares every field
// while the result side stalls on its own pattern, once for a long stretch
// ---------------------------------------------------------------------------
module tb_humidity_temp_readout_decoder;

  localparam logic [1:0] CMD_UNASSIGNED = 2'd3;
  localparam int IDLE_LIMIT = 5000;
  localparam int RANDOM_FRAMES = 1250;
  localparam int HOLD_AT = 400;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [7:0]  check_b;
    logic [15:0] word_b;
    logic [7:0]  check_a;
    logic [15:0] word_a;
  } frame_t;

  typedef struct {
    logic [1:0] cmd;
    frame_t     fr;
  } request_t;

  typedef struct {
    logic        frame_status;
    logic        temp_ok;
    logic        hum_ok;
    logic [14:0] temperature;
    logic [15:0] humidity;
    logic [31:0] serial_word;
  } readout_t;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_RARE_STALL} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [2:0]  out_tuser;

  request_t pending_frames[$];
  readout_t expected_readouts[$];
  int       errors = 0;
  int       frames_sent = 0;
  int       frames_total = 0;
  int       readouts_seen = 0;
  int       n_measure = 0;
  int       n_serial = 0;
  int       n_soft = 0;
  int       n_unassigned = 0;
  int       n_crc_bad = 0;

  humidity_temp_readout_decoder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // bit-serial crc, msb first, over the given number of leading bits
  function automatic logic [7:0] crc_bits(logic [23:0] bits, int nbits);
    logic [7:0] crc;
    logic       fb;
    crc = htrd_pkg::CRC_INIT;
    for (int i = 23; i > 23 - nbits; i--) begin
      fb = crc[7] ^ bits[i];
      crc = {crc[6:0], 1'b0} ^ (fb ? htrd_pkg::CRC_POLY : 8'h00);
    end
    return crc;
  endfunction

  function automatic logic [7:0] good_check(logic [15:0] word);
    return crc_bits({word, 8'h00}, 16);
  endfunction

  function automatic logic word_intact(logic [15:0] word, logic [7:0] check);
    return crc_bits({word, check}, 24) == 8'h00;
  endfunction

  function automatic readout_t decode_frame(logic [1:0] cmd, frame_t fr);
    readout_t r;
    longint   num;
    longint   hum;
    r.temp_ok = word_intact(fr.word_a, fr.check_a);
    r.hum_ok = word_intact(fr.word_b, fr.check_b);
    r.frame_status = !(r.temp_ok && r.hum_ok);
    r.temperature = '0;
    r.humidity = '0;
    r.serial_word = '0;
    if (cmd == htrd_pkg::CMD_SERIAL) begin
      r.serial_word = r.frame_status ? 32'hffff_ffff : {fr.word_a, fr.word_b};
    end else if (cmd != htrd_pkg::CMD_SOFT_RESET) begin
      // longint division truncates toward zero
      num = longint'(fr.word_a) * 17500 - longint'(4500) * 65535;
      num = num / 65535;
      hum = longint'(fr.word_b) * 1000 / 65535;
      r.temperature = r.temp_ok ? num[14:0] : 15'h7fff;
      r.humidity = r.hum_ok ? hum[15:0] : 16'hffff;
    end
    return r;
  endfunction

  task automatic add_frame(logic [1:0] cmd, logic [15:0] wa, logic [7:0] flip_a,
                           logic [15:0] wb, logic [7:0] flip_b);
    request_t q;
    q.cmd = cmd;
    q.fr.word_a = wa;
    q.fr.check_a = good_check(wa) ^ flip_a;
    q.fr.word_b = wb;
    q.fr.check_b = good_check(wb) ^ flip_b;
    pending_frames.push_back(q);
  endtask

  function automatic logic [15:0] random_word();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [1:0] random_cmd();
    int r;
    r = $urandom_range(0, 19);
    if (r < 8) return htrd_pkg::CMD_MEASURE;
    if (r < 14) return htrd_pkg::CMD_SERIAL;
    if (r < 17) return htrd_pkg::CMD_SOFT_RESET;
    return CMD_UNASSIGNED;
  endfunction

  task automatic add_random_frame();
    request_t q;
    logic [7:0] flip;
    q.cmd = random_cmd();
    q.fr.word_a = random_word();
    q.fr.word_b = random_word();
    q.fr.check_a = good_check(q.fr.word_a);
    q.fr.check_b = good_check(q.fr.word_b);
    flip = 8'($urandom_range(1, 255));
    case ($urandom_range(0, 11))
      8: q.fr.check_a ^= flip;
      9: q.fr.check_b ^= flip;
      10: q.fr.word_a[$urandom_range(0, 15)] ^= 1'b1;
      11: begin
        q.fr.check_a = 8'($urandom);
        q.fr.check_b = 8'($urandom);
      end
      default: ;
    endcase
    pending_frames.push_back(q);
  endtask

  // driver: bursts of transfers separated by random gaps
  always @(posedge clk) begin
    int       burst_left;
    int       gap_left;
    request_t q;
    readout_t want;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        want = decode_frame(in_tuser, frame_t'(in_tdata));
        expected_readouts.push_back(want);
        frames_sent++;
        case (in_tuser)
          htrd_pkg::CMD_SERIAL: n_serial++;
          htrd_pkg::CMD_SOFT_RESET: n_soft++;
          CMD_UNASSIGNED: n_unassigned++;
          default: n_measure++;
        endcase
        if (want.frame_status) n_crc_bad++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          in_tvalid <= 1'b0;
          gap_left--;
        end else if (pending_frames.size() > 0) begin
          q = pending_frames.pop_front();
          in_tdata <= q.fr;
          in_tuser <= q.cmd;
          in_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern switches mode now and then, one long hold-off
  always @(posedge clk) begin
    rx_mode_t mode;
    int       mode_left;
    int       phase;
    int       hold_left;
    bit       hold_done;
    if (!rst_n) begin
      out_tready <= 1'b0;
      mode = RX_OPEN;
      mode_left = 0;
      phase = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!hold_done && frames_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_tready <= 1'b0;
      end else begin
        case (mode)
          RX_OPEN: out_tready <= 1'b1;
          RX_RANDOM: out_tready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_tready <= (phase % 3 == 0);
          default: out_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // monitor: compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    readout_t             want;
    htrd_pkg::out_flags_t flags;
    htrd_pkg::out_data_t  data;
    if (rst_n && out_tvalid && out_tready) begin
      flags = htrd_pkg::out_flags_t'(out_tuser);
      data = htrd_pkg::out_data_t'(out_tdata[62:0]);
      readouts_seen++;
      if (expected_readouts.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %0h/%0h",
                 $time, out_tuser, out_tdata);
      end else begin
        want = expected_readouts.pop_front();
        check_field("frame_status", want.frame_status, flags.frame_status);
        check_field("temp_ok", want.temp_ok, flags.temp_ok);
        check_field("hum_ok", want.hum_ok, flags.hum_ok);
        check_field("temperature", want.temperature, data.temperature);
        check_field("humidity", want.humidity, data.humidity);
        check_field("serial_word", want.serial_word, data.serial_word);
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    int idle;
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle = 0;
    end else begin
      idle++;
      if (idle >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    // extremes, every command, crc faults on either word, truncation near zero
    add_frame(htrd_pkg::CMD_MEASURE, 16'h0000, 8'h00, 16'h0000, 8'h00);
    add_frame(htrd_pkg::CMD_MEASURE, 16'hffff, 8'h00, 16'hffff, 8'h00);
    add_frame(htrd_pkg::CMD_MEASURE, 16'd16851, 8'h00, 16'd1, 8'h00);
    add_frame(htrd_pkg::CMD_MEASURE, 16'd16852, 8'h00, 16'hfffe, 8'h00);
    add_frame(htrd_pkg::CMD_MEASURE, 16'd1, 8'h01, 16'h8000, 8'h00);
    add_frame(htrd_pkg::CMD_MEASURE, 16'h7fff, 8'h00, 16'h1234, 8'h80);
    add_frame(htrd_pkg::CMD_MEASURE, 16'hfffe, 8'hff, 16'h00ff, 8'hff);
    add_frame(htrd_pkg::CMD_SERIAL, 16'haaaa, 8'h00, 16'h5555, 8'h00);
    add_frame(htrd_pkg::CMD_SERIAL, 16'hffff, 8'h00, 16'hffff, 8'h00);
    add_frame(htrd_pkg::CMD_SERIAL, 16'h0000, 8'h00, 16'h0000, 8'h00);
    add_frame(htrd_pkg::CMD_SERIAL, 16'h1357, 8'h10, 16'h2468, 8'h00);
    add_frame(htrd_pkg::CMD_SERIAL, 16'h1357, 8'h00, 16'h2468, 8'h02);
    add_frame(htrd_pkg::CMD_SOFT_RESET, 16'h4321, 8'h00, 16'h8765, 8'h00);
    add_frame(htrd_pkg::CMD_SOFT_RESET, 16'hffff, 8'h40, 16'h0000, 8'h04);
    add_frame(CMD_UNASSIGNED, 16'h6666, 8'h00, 16'h9999, 8'h00);
    add_frame(CMD_UNASSIGNED, 16'h6666, 8'h20, 16'h9999, 8'h00);
    add_frame(CMD_UNASSIGNED, 16'hffff, 8'h00, 16'h0000, 8'h08);
    for (int i = 0; i < RANDOM_FRAMES; i++) begin
      add_random_frame();
    end
    frames_total = pending_frames.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (frames_sent < frames_total) @(posedge clk);
    while (expected_readouts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d frames: %0d measure, %0d serial, %0d soft reset, %0d code 3",
             frames_sent, n_measure, n_serial, n_soft, n_unassigned);
    $display("%0d frames with a crc fault, %0d results checked, %0d mismatches",
             n_crc_bad, readouts_seen, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
